/* hdl/sliding_window_anagram_matcher_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the anagram matcher
// Concurrent checks sampled on the rising clock edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_ANAGRAM_MATCHER_TOP_MACROS_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCHER_TOP_MACROS_SVH

// Condition must hold at every edge out of reset.
`define SWAM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SWAM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/swam_pkg.sv */
// ----------------------------------------------------------------------------
// swam_pkg
// Shared types and constants of the sliding window anagram matcher.
// ----------------------------------------------------------------------------
package swam_pkg;

    localparam int NUM_LETTERS = 26;
    localparam int LETTER_W    = 5;
    localparam int REQ_W       = 2;
    localparam int START_W     = 16;

    localparam int              MAX_PATTERN_DEF = 1024;
    localparam longint unsigned MAX_TEXT_DEF    = 64'd65536;

    // result queue depth, power of two
    localparam int RES_DEPTH = 4;

    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_PAT   = 3'd2,
        OP_OVF   = 3'd3,
        OP_TEXT  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [LETTER_W-1:0] code;
        logic                full;   // a letter leaves the window
        logic                cand;   // window is complete after this letter
        logic [START_W-1:0]  start;
    } t_stage;

    typedef struct packed {
        logic               match;
        logic [START_W-1:0] start_index;
        logic               pattern_overflow;
    } t_result;

endpackage

/* hdl/swam_ram.sv */
// ----------------------------------------------------------------------------
// swam_ram
// Generic RAM: one write port, N_RD registered read ports, read-first.
// ----------------------------------------------------------------------------
module swam_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    parameter int  N_RD  = 1,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr [N_RD],
    output logic [WIDTH-1:0] o_rdata [N_RD]
);

    logic [WIDTH-1:0] r_mem   [DEPTH];
    logic [WIDTH-1:0] r_rdata [N_RD];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        for (int r = 0; r < N_RD; r++) begin
            r_rdata[r] <= r_mem[i_raddr[r]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/swam_res_fifo.sv */
// ----------------------------------------------------------------------------
// swam_res_fifo
// Small result queue in flops; the head word drives the output port.
// ----------------------------------------------------------------------------
module swam_res_fifo #(
    parameter int  DEPTH = swam_pkg::RES_DEPTH,
    localparam int AW    = $clog2(DEPTH),
    localparam int CNTW  = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  swam_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output swam_pkg::t_result o_data,
    output logic [CNTW-1:0]   o_count
);

    swam_pkg::t_result r_buf [DEPTH];
    logic [AW-1:0]     r_wptr, n_wptr;
    logic [AW-1:0]     r_rptr, n_rptr;
    logic [CNTW-1:0]   r_count, n_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_pop;
    assign o_data  = r_buf[r_rptr];
    assign o_count = r_count;

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + CNTW'(i_push) - CNTW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

endmodule

/* hdl/sliding_window_anagram_matcher_top.sv */
// ----------------------------------------------------------------------------
// Sliding window anagram matcher
// Streams pattern and text letters and flags each text window that is an
// anagram of the pattern.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one request word: clear,
// add a pattern letter, or feed a text letter. Output channel (o_out_valid /
// i_out_ready) returns exactly one result word per request word, in order.
// Each word passes the stage 1 and stage 2 registers into the result queue.
// One word is accepted per cycle while o_in_ready is high: the ring memory is
// read at accept, the three count memories are read in the next cycle with the
// leaving letter and written back from stage 2, forwarded into the next word.
// A 4-deep result queue absorbs output stalls; o_in_ready drops only when the
// words in flight plus the queued results fill that queue.
// Reset (synchronous, active low) empties the pattern, the window and the
// queue; count entries read as zero until written again, so no clearing pass
// is needed. A clear word has the same effect on the matcher state.
// ----------------------------------------------------------------------------
`include "sliding_window_anagram_matcher_top_macros.svh"

module sliding_window_anagram_matcher_top #(
    parameter int              MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF,
    parameter longint unsigned MAX_TEXT    = swam_pkg::MAX_TEXT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [swam_pkg::REQ_W-1:0]    i_req_type,
    input  logic [swam_pkg::LETTER_W-1:0] i_letter,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_match,
    output logic [swam_pkg::START_W-1:0]  o_start_index,
    output logic                          o_pattern_overflow
);

    localparam int LW   = swam_pkg::LETTER_W;
    localparam int NL   = swam_pkg::NUM_LETTERS;
    localparam int CW   = $clog2(MAX_PATTERN + 1);
    localparam int RAW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PW   = $clog2(MAX_TEXT);
    localparam int QD   = swam_pkg::RES_DEPTH;
    localparam int CNTW = $clog2(QD + 1);
    localparam logic [PW:0] MT = (PW + 1)'(MAX_TEXT);

    typedef struct packed {
        logic          v;
        logic [LW-1:0] addr;
        logic [CW-1:0] data;
    } t_fwd;

    function automatic logic [CW-1:0] f_fetch(input logic [CW-1:0] rd, input logic vld,
                                              input t_fwd fw, input logic [LW-1:0] addr);
        logic [CW-1:0] val;
        val = vld ? rd : '0;
        if (fw.v && fw.addr == addr) begin
            val = fw.data;
        end
        return val;
    endfunction

    // ---------------- control registers (updated at accept) ----------------
    logic [CW-1:0]  r_pat_len, n_pat_len;
    logic [CW-1:0]  r_fill, n_fill;
    logic [RAW-1:0] r_head, n_head;
    logic [PW-1:0]  r_pos, n_pos;
    logic [PW-1:0]  r_back, n_back;   // (pattern length - 1) mod MAX_TEXT

    logic              r_s1_v, r_s2_v;
    swam_pkg::t_stage  r_s1, r_s2, s0;
    logic [LW-1:0]     r_s2_leave;

    logic [NL-1:0] r_a_vld, n_a_vld;
    logic [NL-1:0] r_b_vld, n_b_vld;
    logic [NL-1:0] r_p_vld, n_p_vld;
    logic [4:0]    r_diff, n_diff;
    t_fwd          r_fwa, r_fwb, r_fwp, n_fwa, n_fwb, n_fwp;

    logic              in_acc, code_ok, fill_full;
    logic [CNTW:0]     occ;
    logic [CNTW-1:0]   fifo_cnt;
    logic              out_pop;
    swam_pkg::t_result res, q_head;

    logic [CW-1:0] head_p1;
    logic [PW:0]   pos_p1, back_p1, start_w;
    logic [PW-1:0] pos_inc, back_inc;

    // ring memory
    logic           ring_we;
    logic [RAW-1:0] ring_waddr;
    logic [RAW-1:0] ring_raddr [1];
    logic [LW-1:0]  ring_rdata [1];

    // count memories: enter counts, leave counts, pattern counts
    logic [LW-1:0] cnt_raddr [2];
    logic [CW-1:0] a_rdata [2];
    logic [CW-1:0] b_rdata [2];
    logic [CW-1:0] p_rdata [2];

    logic [CW-1:0] ac, al, bl, bc, pc, pl, wc, wl;
    logic          was_c, now_c, was_l, now_l;
    logic [1:0]    inc, dec;

    assign occ        = (CNTW + 1)'(r_s1_v) + (CNTW + 1)'(r_s2_v) + (CNTW + 1)'(fifo_cnt);
    assign o_in_ready = (occ < (CNTW + 1)'(QD));
    assign in_acc     = i_in_valid && o_in_ready;
    assign code_ok    = (i_letter < LW'(NL));
    assign fill_full  = (r_fill >= r_pat_len);

    assign head_p1  = CW'(r_head) + 1'b1;
    assign pos_p1   = {1'b0, r_pos} + 1'b1;
    assign back_p1  = {1'b0, r_back} + 1'b1;
    assign pos_inc  = (pos_p1 == MT) ? '0 : pos_p1[PW-1:0];
    assign back_inc = (back_p1 == MT) ? '0 : back_p1[PW-1:0];
    assign start_w  = (r_pos >= r_back) ? ({1'b0, r_pos} - {1'b0, r_back})
                                        : ({1'b0, r_pos} + MT - {1'b0, r_back});

    // ---------------- stage 0: decode, ring access, bookkeeping -------------
    always_comb begin
        n_pat_len  = r_pat_len;
        n_fill     = r_fill;
        n_head     = r_head;
        n_pos      = r_pos;
        n_back     = r_back;
        ring_we    = 1'b0;
        ring_waddr = r_head;
        s0         = '{op: swam_pkg::OP_NONE, code: i_letter, full: 1'b0,
                       cand: 1'b0, start: '0};
        if (in_acc) begin
            unique case (i_req_type)
                swam_pkg::REQ_CLEAR: begin
                    s0.op     = swam_pkg::OP_CLEAR;
                    n_pat_len = '0;
                    n_fill    = '0;
                    n_head    = '0;
                    n_pos     = '0;
                    n_back    = '0;
                end
                swam_pkg::REQ_PATTERN: begin
                    if (code_ok) begin
                        if (r_pat_len >= CW'(MAX_PATTERN)) begin
                            s0.op = swam_pkg::OP_OVF;
                        end else begin
                            // add the letter and restart the text
                            s0.op     = swam_pkg::OP_PAT;
                            n_pat_len = r_pat_len + 1'b1;
                            n_back    = (r_pat_len == '0) ? '0 : back_inc;
                            n_fill    = '0;
                            n_head    = '0;
                            n_pos     = '0;
                        end
                    end
                end
                swam_pkg::REQ_TEXT: begin
                    if (code_ok) begin
                        n_pos = pos_inc;
                        if (r_pat_len != '0) begin
                            s0.op    = swam_pkg::OP_TEXT;
                            s0.full  = fill_full;
                            s0.cand  = fill_full || (r_fill + 1'b1 == r_pat_len);
                            s0.start = swam_pkg::START_W'(start_w);
                            ring_we  = 1'b1;
                            if (fill_full) begin
                                // new letter takes the oldest slot, read-first
                                ring_waddr = r_head;
                                n_head     = (head_p1 >= r_pat_len) ? '0 : head_p1[RAW-1:0];
                            end else begin
                                ring_waddr = r_fill[RAW-1:0];
                                n_fill     = r_fill + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign ring_raddr[0] = r_head;

    swam_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_PATTERN),
        .N_RD  (1)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (i_letter),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // ---------------- stage 1: count reads at entering and leaving letter ---
    assign cnt_raddr[0] = r_s1.code;
    assign cnt_raddr[1] = ring_rdata[0];

    // ---------------- stage 2: modify and write back ------------------------
    always_comb begin
        ac = f_fetch(a_rdata[0], r_a_vld[r_s2.code],  r_fwa, r_s2.code);
        al = f_fetch(a_rdata[1], r_a_vld[r_s2_leave], r_fwa, r_s2_leave);
        bc = f_fetch(b_rdata[0], r_b_vld[r_s2.code],  r_fwb, r_s2.code);
        bl = f_fetch(b_rdata[1], r_b_vld[r_s2_leave], r_fwb, r_s2_leave);
        pc = f_fetch(p_rdata[0], r_p_vld[r_s2.code],  r_fwp, r_s2.code);
        pl = f_fetch(p_rdata[1], r_p_vld[r_s2_leave], r_fwp, r_s2_leave);
        // window count is the modular difference of entries and exits
        wc    = ac - bc;
        wl    = al - bl;
        was_c = (wc != pc);
        now_c = (wc + 1'b1 != pc);
        was_l = (wl != pl);
        now_l = (wl - 1'b1 != pl);
        inc   = '0;
        dec   = '0;
        if (!r_s2.full) begin
            inc = {1'b0, !was_c && now_c};
            dec = {1'b0, was_c && !now_c};
        end else if (r_s2_leave != r_s2.code) begin
            inc = 2'(!was_c && now_c) + 2'(!was_l && now_l);
            dec = 2'(was_c && !now_c) + 2'(was_l && !now_l);
        end

        n_a_vld = r_a_vld;
        n_b_vld = r_b_vld;
        n_p_vld = r_p_vld;
        n_diff  = r_diff;
        n_fwa   = '{v: 1'b0, addr: r_s2.code,  data: ac + 1'b1};
        n_fwb   = '{v: 1'b0, addr: r_s2_leave, data: bl + 1'b1};
        n_fwp   = '{v: 1'b0, addr: r_s2.code,  data: pc + 1'b1};
        res     = '{match: 1'b0, start_index: '0, pattern_overflow: 1'b0};

        if (r_s2_v) begin
            unique case (r_s2.op)
                swam_pkg::OP_CLEAR: begin
                    n_a_vld = '0;
                    n_b_vld = '0;
                    n_p_vld = '0;
                    n_diff  = '0;
                end
                swam_pkg::OP_PAT: begin
                    n_a_vld             = '0;
                    n_b_vld             = '0;
                    n_p_vld[r_s2.code]  = 1'b1;
                    n_fwp.v             = 1'b1;
                    n_diff              = 5'($countones(n_p_vld));
                end
                swam_pkg::OP_OVF: begin
                    res.pattern_overflow = 1'b1;
                end
                swam_pkg::OP_TEXT: begin
                    n_a_vld[r_s2.code] = 1'b1;
                    n_fwa.v            = 1'b1;
                    if (r_s2.full) begin
                        n_b_vld[r_s2_leave] = 1'b1;
                        n_fwb.v             = 1'b1;
                    end
                    n_diff = r_diff + {3'b0, inc} - {3'b0, dec};
                    if (r_s2.cand && n_diff == '0) begin
                        res.match       = 1'b1;
                        res.start_index = r_s2.start;
                    end
                end
                default: ;
            endcase
        end
    end

    swam_ram #(
        .WIDTH (CW),
        .DEPTH (NL),
        .N_RD  (2)
    ) u_enter_cnt (
        .i_clk   (i_clk),
        .i_we    (n_fwa.v),
        .i_waddr (n_fwa.addr),
        .i_wdata (n_fwa.data),
        .i_raddr (cnt_raddr),
        .o_rdata (a_rdata)
    );

    swam_ram #(
        .WIDTH (CW),
        .DEPTH (NL),
        .N_RD  (2)
    ) u_leave_cnt (
        .i_clk   (i_clk),
        .i_we    (n_fwb.v),
        .i_waddr (n_fwb.addr),
        .i_wdata (n_fwb.data),
        .i_raddr (cnt_raddr),
        .o_rdata (b_rdata)
    );

    swam_ram #(
        .WIDTH (CW),
        .DEPTH (NL),
        .N_RD  (2)
    ) u_pattern_cnt (
        .i_clk   (i_clk),
        .i_we    (n_fwp.v),
        .i_waddr (n_fwp.addr),
        .i_wdata (n_fwp.data),
        .i_raddr (cnt_raddr),
        .o_rdata (p_rdata)
    );

    // ---------------- registers ---------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_fill    <= '0;
            r_head    <= '0;
            r_pos     <= '0;
            r_back    <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_a_vld   <= '0;
            r_b_vld   <= '0;
            r_p_vld   <= '0;
            r_diff    <= '0;
            r_fwa.v   <= 1'b0;
            r_fwb.v   <= 1'b0;
            r_fwp.v   <= 1'b0;
        end else begin
            r_pat_len <= n_pat_len;
            r_fill    <= n_fill;
            r_head    <= n_head;
            r_pos     <= n_pos;
            r_back    <= n_back;
            r_s1_v    <= in_acc;
            r_s2_v    <= r_s1_v;
            r_a_vld   <= n_a_vld;
            r_b_vld   <= n_b_vld;
            r_p_vld   <= n_p_vld;
            r_diff    <= n_diff;
            r_fwa     <= n_fwa;
            r_fwb     <= n_fwb;
            r_fwp     <= n_fwp;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_s1       <= s0;
        r_s2       <= r_s1;
        r_s2_leave <= ring_rdata[0];
    end

    // ---------------- result queue ------------------------------------------
    swam_res_fifo #(
        .DEPTH (QD)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_v),
        .i_data  (res),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (q_head),
        .o_count (fifo_cnt)
    );

    assign out_pop            = o_out_valid && i_out_ready;
    assign o_match            = q_head.match;
    assign o_start_index      = q_head.start_index;
    assign o_pattern_overflow = q_head.pattern_overflow;

    // ---------------- assertions --------------------------------------------
    `SWAM_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, r_s2_v,
        (fifo_cnt < CNTW'(QD)) || out_pop, "result word pushed into a full queue")
    `SWAM_ASSERT_ALWAYS(a_diff_range, i_clk, i_rst_n, r_diff <= 5'(NL),
        "differing letter count out of range")
    `SWAM_ASSERT_ALWAYS(a_fill_le_len, i_clk, i_rst_n, r_fill <= r_pat_len,
        "window fill exceeds pattern length")
    `SWAM_ASSERT_IMPLY(a_head_range, i_clk, i_rst_n, r_pat_len != '0,
        CW'(r_head) < r_pat_len, "ring head beyond pattern length")

endmodule
